// File: src/ofb_pkg.sv
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared types and constants for the orthonormal basis pipeline.
// ----------------------------------------------------------------------------
package ofb_pkg;

    // Unit length in Q2.14
    localparam int AXIS_ONE = 16384;
    // Largest component kept before normalization
    localparam int MAG_LIMIT = 32768;
    // Width of the cross(up, z) components
    localparam int CROSS_W = 33;

    typedef logic [2:0][15:0] t_vec16;
    typedef logic [2:0][23:0] t_vec24;

    // Fallback axes, element 0 is the x component
    localparam t_vec16 Z_DEFAULT = {16'sd16384, 16'sd0, 16'sd0};
    localparam t_vec16 X_DEFAULT = {16'sd0, 16'sd0, 16'sd16384};

    typedef struct packed {
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } t_in_data;

    typedef struct packed {
        logic signed [15:0] axis_x_x;
        logic signed [15:0] axis_x_y;
        logic signed [15:0] axis_x_z;
        logic signed [15:0] axis_y_x;
        logic signed [15:0] axis_y_y;
        logic signed [15:0] axis_y_z;
        logic signed [15:0] axis_z_x;
        logic signed [15:0] axis_z_y;
        logic signed [15:0] axis_z_z;
        logic signed [23:0] out_pos_x;
        logic signed [23:0] out_pos_y;
        logic signed [23:0] out_pos_z;
    } t_out_data;

endpackage

// File: src/ofb_if.sv
// ----------------------------------------------------------------------------
// ofb_if
// Valid/ready request channels for the basis pipeline input and output.
// ----------------------------------------------------------------------------
interface ofb_in_if;
    logic              valid;
    logic              ready;
    ofb_pkg::t_in_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ofb_out_if;
    logic               valid;
    logic               ready;
    ofb_pkg::t_out_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/ofb_norm.sv
// ----------------------------------------------------------------------------
// ofb_norm
// Pipelined exact vector normalization to Q2.14, one bit of the root a stage.
// ----------------------------------------------------------------------------
module ofb_norm #(
    parameter int IN_W   = 16,
    parameter int SIDE_W = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2:0][IN_W-1:0]   i_vec,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output ofb_pkg::t_vec16        o_unit,
    output logic                   o_zero,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int MAX_SH  = IN_W - 16;
    localparam int SH_W    = $clog2(MAX_SH + 2);
    localparam int RT_BITS = 16;            // root s = floor(2^15 m / sqrt(L))
    localparam int BS0     = 4;             // stage holding initial remainder
    localparam int BS_LAST = BS0 + RT_BITS; // last root bit stage
    localparam int NS      = BS_LAST + 2;
    localparam int SQ_W    = 32;
    localparam int RRW     = SQ_W + 30;
    localparam int PW      = SQ_W + RT_BITS;
    localparam int RW      = PW + RT_BITS + 2;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_adv;

    logic [2:0][IN_W-1:0] r_m0;
    logic [2:0][IN_W-1:0] r_m1;
    logic [SH_W-1:0]      r_sh;
    logic [SH_W-1:0]      w_sh;
    logic [2:0][15:0]     r_m2;
    logic [2:0][SQ_W-1:0] r_sq;

    logic [2:0]        r_neg  [0:NS-2];
    logic              r_zero [0:NS-1];
    logic [SIDE_W-1:0] r_side [0:NS-1];

    logic [SQ_W-1:0]      r_l [BS0:BS_LAST-1];
    logic [2:0][RRW-1:0]  r_r [BS0:BS_LAST-1];
    logic [2:0][PW-1:0]   r_p [BS0:BS_LAST-1];
    logic [2:0][15:0]     r_s [BS0:BS_LAST];

    ofb_pkg::t_vec16 r_u;

    // Stall chain: a stage moves when it is empty or its successor moves
    assign w_adv[NS] = i_ready;
    for (genvar gi = 0; gi < NS; gi++) begin : g_adv
        assign w_adv[gi] = ~r_v[gi] | w_adv[gi+1];
    end
    assign o_ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (w_adv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // Flags and side payload ride along
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_zero[0] <= (i_vec == '0);
            r_side[0] <= i_side;
            for (int j = 0; j < 3; j++) begin
                r_neg[0][j] <= i_vec[j][IN_W-1];
            end
        end
        for (int i = 1; i < NS; i++) begin
            if (w_adv[i]) begin
                r_zero[i] <= r_zero[i-1];
                r_side[i] <= r_side[i-1];
            end
        end
        for (int i = 1; i < NS - 1; i++) begin
            if (w_adv[i]) begin
                r_neg[i] <= r_neg[i-1];
            end
        end
    end

    // Smallest shift that brings every magnitude to 32768 or less
    always_comb begin
        w_sh = '0;
        for (int n = MAX_SH; n >= 0; n--) begin
            if ((r_m0[0] >> n) <= IN_W'(ofb_pkg::MAG_LIMIT) &&
                (r_m0[1] >> n) <= IN_W'(ofb_pkg::MAG_LIMIT) &&
                (r_m0[2] >> n) <= IN_W'(ofb_pkg::MAG_LIMIT)) begin
                w_sh = SH_W'(n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (w_adv[0]) begin
                r_m0[j] <= i_vec[j][IN_W-1] ? (~i_vec[j] + 1'b1) : i_vec[j];
            end
            if (w_adv[1]) begin
                r_m1[j] <= r_m0[j];
            end
            if (w_adv[2]) begin
                r_m2[j] <= 16'(r_m1[j] >> r_sh);
            end
            if (w_adv[3]) begin
                r_sq[j] <= SQ_W'(r_m2[j]) * SQ_W'(r_m2[j]);
            end
            if (w_adv[BS0]) begin
                r_r[BS0][j] <= {r_sq[j], 30'b0};
                r_p[BS0][j] <= '0;
                r_s[BS0][j] <= '0;
            end
        end
        if (w_adv[1]) begin
            r_sh <= w_sh;
        end
        if (w_adv[BS0]) begin
            r_l[BS0] <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // Restoring root, one bit per stage: R = 2^30 m^2 - s^2 L, P = s L
    for (genvar gb = 0; gb < RT_BITS; gb++) begin : g_bit
        localparam int K  = RT_BITS - 1 - gb;
        localparam int ST = BS0 + 1 + gb;

        logic [2:0][RW-1:0] w_t;
        logic [2:0]         w_ge;

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                w_t[j]  = (RW'(r_p[ST-1][j]) << (K + 1)) + (RW'(r_l[ST-1]) << (2 * K));
                w_ge[j] = RW'(r_r[ST-1][j]) >= w_t[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[ST]) begin
                for (int j = 0; j < 3; j++) begin
                    r_s[ST][j] <= w_ge[j] ? (r_s[ST-1][j] | (16'(1) << K))
                                          : r_s[ST-1][j];
                end
            end
        end

        if (ST < BS_LAST) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_adv[ST]) begin
                    r_l[ST] <= r_l[ST-1];
                    for (int j = 0; j < 3; j++) begin
                        if (w_ge[j]) begin
                            r_r[ST][j] <= r_r[ST-1][j] - w_t[j][RRW-1:0];
                            r_p[ST][j] <= r_p[ST-1][j] + (PW'(r_l[ST-1]) << K);
                        end else begin
                            r_r[ST][j] <= r_r[ST-1][j];
                            r_p[ST][j] <= r_p[ST-1][j];
                        end
                    end
                end
            end
        end
    end

    // Round half away: r = (s + 1) / 2, then restore sign
    always_ff @(posedge i_clk) begin
        if (w_adv[NS-1]) begin
            for (int j = 0; j < 3; j++) begin
                r_u[j] <= r_neg[NS-2][j]
                        ? 16'(-(17'(r_s[BS_LAST][j]) + 17'd1 >> 1))
                        : 16'((17'(r_s[BS_LAST][j]) + 17'd1) >> 1);
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_unit  = r_u;
    assign o_zero  = r_zero[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// File: src/orthonormal_basis_from_direction_core.sv
// ----------------------------------------------------------------------------
// orthonormal_basis_from_direction_core
// Look-at frame from front, up and position: three Q2.14 axes plus position.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : request with front and up directions (Q4.12) and a Q12.12
//           position. Taken when valid and ready are high at a clock edge.
//   o_out : request with the x, y and z axes in Q2.14 and the position copy.
// Pipeline: normalize front (22 stages), form cross(up, z) (3 stages),
//   normalize it (22 stages), form y = cross(z, x) (3 stages), with 50
//   register stages in all. One request per cycle enters in steady state
//   while o_out.ready is high, set by the one-root-bit-per-stage
//   normalizers.
// Reset (i_rst_n low, synchronous) empties every stage; requests in flight are dropped.
// Stall: when o_out.ready is low the filled stages hold their contents and
//   empty stages keep filling, so i_in.ready stays high until the pipeline
//   is full. Each stage moves when it is empty or its successor moves.
// Special cases: a zero front gives z = (0, 0, 1); up parallel to z (or
//   zero) gives x = (1, 0, 0); y components saturate to +/-1.0.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_direction_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ofb_in_if.sink        i_in,
    ofb_out_if.source     o_out
);

    localparam int SIDE_W = $bits(ofb_pkg::t_vec16) + $bits(ofb_pkg::t_vec24);
    localparam int CW     = ofb_pkg::CROSS_W;

    // ---------------- front normalizer ----------------
    ofb_pkg::t_vec16        w_front;
    logic [SIDE_W-1:0]      w_nz_side_in;
    logic                   nz_valid;
    logic                   nz_ready;
    ofb_pkg::t_vec16        nz_unit;
    logic                   nz_zero;
    logic [SIDE_W-1:0]      nz_side;

    assign w_front      = {i_in.data.front_z, i_in.data.front_y, i_in.data.front_x};
    assign w_nz_side_in = {i_in.data.up_z, i_in.data.up_y, i_in.data.up_x,
                           i_in.data.pos_z, i_in.data.pos_y, i_in.data.pos_x};

    ofb_norm #(
        .IN_W   (16),
        .SIDE_W (SIDE_W)
    ) u_norm_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_vec   (w_front),
        .i_side  (w_nz_side_in),
        .o_valid (nz_valid),
        .i_ready (nz_ready),
        .o_unit  (nz_unit),
        .o_zero  (nz_zero),
        .o_side  (nz_side)
    );

    // ---------------- cross(up, z) stages ----------------
    logic [2:0]          r_av;
    logic [3:0]          w_aadv;
    logic                nx_ready;

    ofb_pkg::t_vec16     r_az0, r_az1, r_az2;
    ofb_pkg::t_vec16     r_up0;
    ofb_pkg::t_vec24     r_ap0, r_ap1, r_ap2;
    logic signed [31:0]  r_pa [6];
    logic [2:0][CW-1:0]  r_c;

    assign w_aadv[3] = nx_ready;
    for (genvar ga = 0; ga < 3; ga++) begin : g_aadv
        assign w_aadv[ga] = ~r_av[ga] | w_aadv[ga+1];
    end
    assign nz_ready = w_aadv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= '0;
        end else begin
            if (w_aadv[0]) r_av[0] <= nz_valid;
            if (w_aadv[1]) r_av[1] <= r_av[0];
            if (w_aadv[2]) r_av[2] <= r_av[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_aadv[0]) begin
            // z is the negated unit front, or +z for a zero front
            for (int j = 0; j < 3; j++) begin
                r_az0[j] <= nz_zero ? ofb_pkg::Z_DEFAULT[j] : -nz_unit[j];
            end
            r_up0 <= nz_side[SIDE_W-1 -: $bits(ofb_pkg::t_vec16)];
            r_ap0 <= nz_side[$bits(ofb_pkg::t_vec24)-1:0];
        end
        if (w_aadv[1]) begin
            r_pa[0] <= $signed(r_up0[1]) * $signed(r_az0[2]);
            r_pa[1] <= $signed(r_up0[2]) * $signed(r_az0[1]);
            r_pa[2] <= $signed(r_up0[2]) * $signed(r_az0[0]);
            r_pa[3] <= $signed(r_up0[0]) * $signed(r_az0[2]);
            r_pa[4] <= $signed(r_up0[0]) * $signed(r_az0[1]);
            r_pa[5] <= $signed(r_up0[1]) * $signed(r_az0[0]);
            r_az1   <= r_az0;
            r_ap1   <= r_ap0;
        end
        if (w_aadv[2]) begin
            for (int j = 0; j < 3; j++) begin
                r_c[j] <= CW'(r_pa[2*j]) - CW'(r_pa[2*j+1]);
            end
            r_az2 <= r_az1;
            r_ap2 <= r_ap1;
        end
    end

    // ---------------- x axis normalizer ----------------
    logic                   nx_valid;
    logic                   nx_out_ready;
    ofb_pkg::t_vec16        nx_unit;
    logic                   nx_zero;
    logic [SIDE_W-1:0]      nx_side;

    ofb_norm #(
        .IN_W   (CW),
        .SIDE_W (SIDE_W)
    ) u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_av[2]),
        .o_ready (nx_ready),
        .i_vec   (r_c),
        .i_side  ({r_az2, r_ap2}),
        .o_valid (nx_valid),
        .i_ready (nx_out_ready),
        .o_unit  (nx_unit),
        .o_zero  (nx_zero),
        .o_side  (nx_side)
    );

    // ---------------- y = cross(z, x) and output ----------------
    logic [2:0]          r_bv;
    logic [3:0]          w_badv;

    ofb_pkg::t_vec16     r_bx0, r_bx1;
    ofb_pkg::t_vec16     r_bz0, r_bz1;
    ofb_pkg::t_vec24     r_bp0, r_bp1;
    logic signed [31:0]  r_py [6];
    ofb_pkg::t_out_data  r_out;

    logic signed [CW-1:0] w_yd [3];
    logic signed [CW-1:0] w_yr [3];
    ofb_pkg::t_vec16      w_y;

    assign w_badv[3] = o_out.ready;
    for (genvar gb = 0; gb < 3; gb++) begin : g_badv
        assign w_badv[gb] = ~r_bv[gb] | w_badv[gb+1];
    end
    assign nx_out_ready = w_badv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else begin
            if (w_badv[0]) r_bv[0] <= nx_valid;
            if (w_badv[1]) r_bv[1] <= r_bv[0];
            if (w_badv[2]) r_bv[2] <= r_bv[1];
        end
    end

    // Round to Q2.14 (add half, floor) and clamp to unit range
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_yd[j] = CW'(r_py[2*j]) - CW'(r_py[2*j+1]) + CW'(8192);
            w_yr[j] = w_yd[j] >>> 14;
            if (w_yr[j] > CW'(ofb_pkg::AXIS_ONE)) begin
                w_y[j] = 16'(ofb_pkg::AXIS_ONE);
            end else if (w_yr[j] < -CW'(ofb_pkg::AXIS_ONE)) begin
                w_y[j] = -16'(ofb_pkg::AXIS_ONE);
            end else begin
                w_y[j] = w_yr[j][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_badv[0]) begin
            for (int j = 0; j < 3; j++) begin
                r_bx0[j] <= nx_zero ? ofb_pkg::X_DEFAULT[j] : nx_unit[j];
            end
            r_bz0 <= nx_side[SIDE_W-1 -: $bits(ofb_pkg::t_vec16)];
            r_bp0 <= nx_side[$bits(ofb_pkg::t_vec24)-1:0];
        end
        if (w_badv[1]) begin
            r_py[0] <= $signed(r_bz0[1]) * $signed(r_bx0[2]);
            r_py[1] <= $signed(r_bz0[2]) * $signed(r_bx0[1]);
            r_py[2] <= $signed(r_bz0[2]) * $signed(r_bx0[0]);
            r_py[3] <= $signed(r_bz0[0]) * $signed(r_bx0[2]);
            r_py[4] <= $signed(r_bz0[0]) * $signed(r_bx0[1]);
            r_py[5] <= $signed(r_bz0[1]) * $signed(r_bx0[0]);
            r_bx1   <= r_bx0;
            r_bz1   <= r_bz0;
            r_bp1   <= r_bp0;
        end
        if (w_badv[2]) begin
            r_out.axis_x_x  <= r_bx1[0];
            r_out.axis_x_y  <= r_bx1[1];
            r_out.axis_x_z  <= r_bx1[2];
            r_out.axis_y_x  <= w_y[0];
            r_out.axis_y_y  <= w_y[1];
            r_out.axis_y_z  <= w_y[2];
            r_out.axis_z_x  <= r_bz1[0];
            r_out.axis_z_y  <= r_bz1[1];
            r_out.axis_z_z  <= r_bz1[2];
            r_out.out_pos_x <= r_bp1[0];
            r_out.out_pos_y <= r_bp1[1];
            r_out.out_pos_z <= r_bp1[2];
        end
    end

    assign o_out.valid = r_bv[2];
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    // Normalized x axis stays in the unit range
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            (r_out.axis_x_x <= 16'sd16384) && (r_out.axis_x_x >= -16'sd16384) &&
            (r_out.axis_x_y <= 16'sd16384) && (r_out.axis_x_y >= -16'sd16384) &&
            (r_out.axis_x_z <= 16'sd16384) && (r_out.axis_x_z >= -16'sd16384))
        else $error("x axis out of range");

    // Saturated y axis stays in the unit range
    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            (r_out.axis_y_x <= 16'sd16384) && (r_out.axis_y_x >= -16'sd16384) &&
            (r_out.axis_y_y <= 16'sd16384) && (r_out.axis_y_y >= -16'sd16384) &&
            (r_out.axis_y_z <= 16'sd16384) && (r_out.axis_y_z >= -16'sd16384))
        else $error("y axis out of range");

    // A zero cross product must leave the x axis at +x
    a_x_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (nx_valid && nx_zero && w_badv[0]) |=>
            (r_bx0 == ofb_pkg::X_DEFAULT))
        else $error("x fallback not applied");
`endif

endmodule
